// ===== rtl/tcfa_pkg.sv =====
// Package for the two-channel frame averager: payload structs, widths,
// register indexes and the controller/datapath command and status types.
// No dependencies.
package tcfa_pkg;

    localparam int MAX_SAMPLES = 64;

    localparam int CHAN_W  = 4;
    localparam int VALUE_W = 12;
    localparam int AVG_W   = 12;
    localparam int SEQ_W   = 32;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = VALUE_W + $clog2(MAX_SAMPLES);
    localparam int STEP_W  = $clog2(SUM_W);

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = CHAN_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_U_CHAN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_V_CHAN = 1'b1;

    localparam logic [CHAN_W-1:0] U_CHAN_RESET = 4'd0;
    localparam logic [CHAN_W-1:0] V_CHAN_RESET = 4'd3;

    typedef struct packed {
        logic [CHAN_W-1:0]  sample_channel;
        logic [VALUE_W-1:0] sample_value;
        logic               frame_end;
    } sample_t;

    typedef struct packed {
        logic [AVG_W-1:0] u_average;
        logic [AVG_W-1:0] v_average;
        logic [SEQ_W-1:0] frame_number;
    } result_t;

    typedef struct packed {
        logic take;
        logic div_step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic publish;
        logic out_free;
    } dp_status_t;

endpackage

// ===== rtl/tcfa_ctrl.sv =====
// Controller of the frame averager: accept, divide and hand-over sequencing.
// Depends on tcfa_pkg.
module tcfa_ctrl
    import tcfa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_ready      = 1'b0;
        cmd.take     = 1'b0;
        cmd.div_step = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
                if (s_valid && status.publish) begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(SUM_W - 1)) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/tcfa_datapath.sv =====
// Datapath of the frame averager: channel registers, accumulators, two
// restoring dividers, sequence counter and output register. Depends on tcfa_pkg.
module tcfa_datapath
    import tcfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  sample_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    logic [CHAN_W-1:0] u_chan_reg, u_chan_next;
    logic [CHAN_W-1:0] v_chan_reg, v_chan_next;
    logic [SUM_W-1:0]  u_sum_reg, u_sum_next, v_sum_reg, v_sum_next;
    logic [CNT_W-1:0]  u_cnt_reg, u_cnt_next, v_cnt_reg, v_cnt_next;
    logic [SUM_W-1:0]  u_quo_reg, u_quo_next, v_quo_reg, v_quo_next;
    logic [CNT_W-1:0]  u_rem_reg, u_rem_next, v_rem_reg, v_rem_next;
    logic [CNT_W-1:0]  u_dsr_reg, u_dsr_next, v_dsr_reg, v_dsr_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;

    logic [SUM_W-1:0]  u_sum_add, v_sum_add;
    logic [CNT_W-1:0]  u_cnt_add, v_cnt_add;
    logic              u_hit, v_hit;
    logic [CNT_W:0]    u_trial, v_trial, u_diff, v_diff;
    logic              u_ge, v_ge;

    // Accumulate the current sample
    always_comb begin
        u_hit     = (s_data.sample_channel == u_chan_reg);
        v_hit     = !u_hit && (s_data.sample_channel == v_chan_reg);
        u_sum_add = u_sum_reg;
        u_cnt_add = u_cnt_reg;
        v_sum_add = v_sum_reg;
        v_cnt_add = v_cnt_reg;
        if (u_hit && (u_cnt_reg < CNT_W'(MAX_SAMPLES))) begin
            u_sum_add = u_sum_reg + SUM_W'(s_data.sample_value);
            u_cnt_add = u_cnt_reg + 1'b1;
        end
        if (v_hit && (v_cnt_reg < CNT_W'(MAX_SAMPLES))) begin
            v_sum_add = v_sum_reg + SUM_W'(s_data.sample_value);
            v_cnt_add = v_cnt_reg + 1'b1;
        end
    end

    assign status.publish  = s_data.frame_end && (u_cnt_add != '0) && (v_cnt_add != '0);
    assign status.out_free = !m_valid_reg || m_ready;

    // One restoring division step per lane
    always_comb begin
        u_trial = {u_rem_reg, u_quo_reg[SUM_W-1]};
        v_trial = {v_rem_reg, v_quo_reg[SUM_W-1]};
        u_diff  = u_trial - {1'b0, u_dsr_reg};
        v_diff  = v_trial - {1'b0, v_dsr_reg};
        u_ge    = (u_trial >= {1'b0, u_dsr_reg});
        v_ge    = (v_trial >= {1'b0, v_dsr_reg});
    end

    always_comb begin
        u_chan_next  = u_chan_reg;
        v_chan_next  = v_chan_reg;
        u_sum_next   = u_sum_reg;
        v_sum_next   = v_sum_reg;
        u_cnt_next   = u_cnt_reg;
        v_cnt_next   = v_cnt_reg;
        u_quo_next   = u_quo_reg;
        v_quo_next   = v_quo_reg;
        u_rem_next   = u_rem_reg;
        v_rem_next   = v_rem_reg;
        u_dsr_next   = u_dsr_reg;
        v_dsr_next   = v_dsr_reg;
        seq_next     = seq_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_U_CHAN: u_chan_next = cfg_wdata;
                CFG_V_CHAN: v_chan_next = cfg_wdata;
                default: ;
            endcase
        end

        if (cmd.take) begin
            if (s_data.frame_end) begin
                u_sum_next = '0;
                v_sum_next = '0;
                u_cnt_next = '0;
                v_cnt_next = '0;
                u_quo_next = u_sum_add + SUM_W'(u_cnt_add >> 1);
                v_quo_next = v_sum_add + SUM_W'(v_cnt_add >> 1);
                u_rem_next = '0;
                v_rem_next = '0;
                u_dsr_next = u_cnt_add;
                v_dsr_next = v_cnt_add;
            end else begin
                u_sum_next = u_sum_add;
                v_sum_next = v_sum_add;
                u_cnt_next = u_cnt_add;
                v_cnt_next = v_cnt_add;
            end
        end

        if (cmd.div_step) begin
            u_quo_next = {u_quo_reg[SUM_W-2:0], u_ge};
            v_quo_next = {v_quo_reg[SUM_W-2:0], v_ge};
            u_rem_next = u_ge ? u_diff[CNT_W-1:0] : u_trial[CNT_W-1:0];
            v_rem_next = v_ge ? v_diff[CNT_W-1:0] : v_trial[CNT_W-1:0];
        end

        if (cmd.load_out) begin
            seq_next                 = seq_reg + 1'b1;
            m_valid_next             = 1'b1;
            m_data_next.u_average    = u_quo_reg[AVG_W-1:0];
            m_data_next.v_average    = v_quo_reg[AVG_W-1:0];
            m_data_next.frame_number = seq_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_chan_reg  <= U_CHAN_RESET;
            v_chan_reg  <= V_CHAN_RESET;
            u_sum_reg   <= '0;
            v_sum_reg   <= '0;
            u_cnt_reg   <= '0;
            v_cnt_reg   <= '0;
            seq_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            u_chan_reg  <= u_chan_next;
            v_chan_reg  <= v_chan_next;
            u_sum_reg   <= u_sum_next;
            v_sum_reg   <= v_sum_next;
            u_cnt_reg   <= u_cnt_next;
            v_cnt_reg   <= v_cnt_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        u_quo_reg  <= u_quo_next;
        v_quo_reg  <= v_quo_next;
        u_rem_reg  <= u_rem_next;
        v_rem_reg  <= v_rem_next;
        u_dsr_reg  <= u_dsr_next;
        v_dsr_reg  <= v_dsr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/two_channel_frame_averager.sv =====
// Top level of the two-channel frame averager: controller plus datapath.
// Depends on tcfa_pkg, tcfa_ctrl and tcfa_datapath.
//
// Sample requests arrive on s_valid/s_ready/s_data (channel tag, 12-bit value,
// frame_end). Samples tagged with the U or V channel register are summed and
// counted, up to 64 per channel per frame; further ones are dropped. Other
// tags are ignored. Ordinary samples are taken one per cycle while idle.
// A frame_end sample closes the frame and clears the accumulators. If both
// channels saw samples, the rounded means are worked out by two restoring
// dividers running side by side, one quotient bit per cycle over the 18-bit
// sum: the input stays closed until the result is loaded, and the result
// request (u_average, v_average, frame_number) then appears on m_valid/m_data.
// The first published frame is number 1; the count wraps.
// The result sits in an output register; while the receiver stalls, the next
// frame's samples are still taken, and only a second finished frame waits
// for m_ready, with s_ready low. Channel registers are written through
// cfg_wr_en/cfg_addr/cfg_wdata (U at 0, V at 1), by the user only while idle;
// the block does not enforce it. Reset (aresetn low, synchronous) sets U to
// channel 0, V to channel 3, clears sums, counts, sequence and output valid.
module two_channel_frame_averager
    import tcfa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sample_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               m_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tcfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tcfa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== rtl/tcfa_checker.sv =====
// Port-level checks for two_channel_frame_averager, attached by bind.
// Depends on tcfa_pkg.
module tcfa_checker
    import tcfa_pkg::*;
(
    input logic    aclk,
    input logic    aresetn,
    input logic    s_valid,
    input logic    s_ready,
    input sample_t s_data,
    input logic    m_valid,
    input logic    m_ready,
    input result_t m_data
);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result request changed");

    a_plain_sample_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_data.frame_end |=> s_ready)
        else $error("input closed after a mid-frame sample");

    a_result_after_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a division phase");

endmodule

bind two_channel_frame_averager tcfa_checker u_tcfa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
